@@ hw/rtl/dmx_pkg.sv @@
// dmx_pkg: shared types, codes and sizes of the DMX512 universe transceiver.
// No dependencies.
`timescale 1ns / 1ps

package dmx_pkg;

    localparam int SLOT_COUNT = 512;
    localparam int SLOT_W     = 10;
    localparam int ADDR_W     = 9;

    localparam logic [2:0] OP_TX_READY   = 3'd0;
    localparam logic [2:0] OP_RX_BYTE    = 3'd1;
    localparam logic [2:0] OP_WRITE_SLOT = 3'd2;
    localparam logic [2:0] OP_READ_TX    = 3'd3;
    localparam logic [2:0] OP_READ_RX    = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;
    localparam logic [2:0] OP_START      = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_MODE  = 2'd2;

    localparam logic [1:0] CFG_MASTER  = 2'd0;
    localparam logic [1:0] CFG_ENABLE  = 2'd1;
    localparam logic [1:0] CFG_MAXSLOT = 2'd2;
    localparam logic [1:0] CFG_DEVADDR = 2'd3;

    localparam logic [1:0] PH_BREAK = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_SLOTS = 2'd2;

    localparam logic [3:0] K_NOP      = 4'd0;
    localparam logic [3:0] K_TX       = 4'd1;
    localparam logic [3:0] K_DISABLE  = 4'd2;
    localparam logic [3:0] K_RX       = 4'd3;
    localparam logic [3:0] K_RX_BREAK = 4'd4;
    localparam logic [3:0] K_WRITE    = 4'd5;
    localparam logic [3:0] K_READ_TX  = 4'd6;
    localparam logic [3:0] K_READ_RX  = 4'd7;
    localparam logic [3:0] K_CLEAR    = 4'd8;
    localparam logic [3:0] K_START    = 4'd9;

    typedef struct packed {
        logic [2:0]        operation;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        data;
        logic              break_flag;
    } req_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_break_rate;
        logic [7:0] read_value;
        logic [7:0] dimmer_level;
        logic [1:0] status;
    } rsp_t;

    typedef struct packed {
        logic [3:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        data;
        logic [1:0]        status;
    } cmd_t;

    typedef struct packed {
        logic              master_mode;
        logic [SLOT_W-1:0] max_slot;
        logic              init_busy;
    } front_ctl_t;

endpackage

@@ hw/rtl/dmx_front.sv @@
// dmx_front: accepts requests, range- and mode-checks them, emits commands.
// Depends on dmx_pkg.
`timescale 1ns / 1ps

module dmx_front (
    input  logic                req_valid,
    output logic                req_ready,
    input  dmx_pkg::req_t       req,
    input  dmx_pkg::front_ctl_t ctl,
    input  logic                fifo_full,
    output logic                push,
    output dmx_pkg::cmd_t       cmd
);

    logic range_bad;

    assign req_ready = !fifo_full && !ctl.init_busy;
    assign push      = req_valid && req_ready;
    assign range_bad = (req.slot == '0) || (req.slot > ctl.max_slot);

    always_comb
    begin
        cmd.slot   = req.slot;
        cmd.data   = req.data;
        cmd.kind   = dmx_pkg::K_NOP;
        cmd.status = dmx_pkg::ST_OK;
        case (req.operation)
            dmx_pkg::OP_TX_READY:
            begin
                if (ctl.master_mode)
                    cmd.kind = dmx_pkg::K_TX;
                else
                begin
                    cmd.kind   = dmx_pkg::K_DISABLE;
                    cmd.status = dmx_pkg::ST_MODE;
                end
            end
            dmx_pkg::OP_RX_BYTE:
            begin
                if (ctl.master_mode)
                    cmd.status = dmx_pkg::ST_MODE;
                else if (req.break_flag)
                    cmd.kind = dmx_pkg::K_RX_BREAK;
                else
                    cmd.kind = dmx_pkg::K_RX;
            end
            dmx_pkg::OP_WRITE_SLOT:
            begin
                if (!ctl.master_mode)
                    cmd.status = dmx_pkg::ST_MODE;
                else if (range_bad)
                    cmd.status = dmx_pkg::ST_RANGE;
                else
                    cmd.kind = dmx_pkg::K_WRITE;
            end
            dmx_pkg::OP_READ_TX:
            begin
                if (range_bad)
                    cmd.status = dmx_pkg::ST_RANGE;
                else
                    cmd.kind = dmx_pkg::K_READ_TX;
            end
            dmx_pkg::OP_READ_RX:
            begin
                if (req.slot > dmx_pkg::SLOT_W'(dmx_pkg::SLOT_COUNT))
                    cmd.status = dmx_pkg::ST_RANGE;
                else
                    cmd.kind = dmx_pkg::K_READ_RX;
            end
            dmx_pkg::OP_CLEAR:
            begin
                if (ctl.master_mode)
                    cmd.kind = dmx_pkg::K_CLEAR;
                else
                    cmd.status = dmx_pkg::ST_MODE;
            end
            dmx_pkg::OP_START:
            begin
                if (ctl.master_mode)
                    cmd.kind = dmx_pkg::K_START;
                else
                    cmd.status = dmx_pkg::ST_MODE;
            end
            default:
                cmd.status = dmx_pkg::ST_MODE;
        endcase
    end

endmodule

@@ hw/rtl/dmx_cmd_fifo.sv @@
// dmx_cmd_fifo: two-entry command queue between front and back.
// Depends on dmx_pkg.
`timescale 1ns / 1ps

module dmx_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dmx_pkg::cmd_t push_cmd,
    input  logic          pop,
    output dmx_pkg::cmd_t pop_cmd,
    output logic          full,
    output logic          empty
);

    dmx_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

@@ hw/rtl/dmx_back.sv @@
// dmx_back: executes commands against the slot tables, frame sequencer,
// configuration registers and result register. Depends on dmx_pkg.
`timescale 1ns / 1ps

module dmx_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [9:0]           cfg_data,
    input  logic                 fifo_empty,
    input  dmx_pkg::cmd_t        cmd,
    output logic                 pop,
    output dmx_pkg::front_ctl_t  ctl,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output dmx_pkg::rsp_t        rsp
);

    localparam logic [1:0] S_INIT  = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_CLEAR = 2'd3;
    localparam int         SW      = dmx_pkg::SLOT_W;
    localparam logic [SW-1:0] LAST = SW'(dmx_pkg::SLOT_COUNT);

    logic [7:0] send_mem [0:dmx_pkg::SLOT_COUNT];
    logic [7:0] recv_mem [0:dmx_pkg::SLOT_COUNT];
    logic [7:0] s_rdata_reg, r_rdata_reg;
    logic          s_we, r_we;
    logic [SW-1:0] s_waddr, s_raddr, r_waddr, r_raddr;
    logic [7:0]    s_wdata, r_wdata;

    logic [1:0]    state_reg, state_next;
    logic [SW-1:0] sweep_reg, sweep_next;
    logic [3:0]    pend_reg, pend_next;
    logic          master_reg, master_next;
    logic          enable_reg, enable_next;
    logic [SW-1:0] max_slot_reg, max_slot_next;
    logic [dmx_pkg::ADDR_W-1:0] dev_reg, dev_next;
    logic [1:0]    phase_reg, phase_next;
    logic [SW-1:0] sidx_reg, sidx_next;
    logic [SW-1:0] ridx_reg, ridx_next;
    logic          busy_reg, busy_next;
    logic [7:0]    latch_reg, latch_next;
    logic          out_valid_reg, out_valid_next;
    dmx_pkg::rsp_t out_reg, out_next;

    logic          out_free, wrap;
    logic [1:0]    phase_eff;
    logic [SW-1:0] sidx_eff;

    assign out_free    = !out_valid_reg || rsp_ready;
    assign pop         = (state_reg == S_IDLE) && !fifo_empty && out_free;
    assign rsp_valid   = out_valid_reg;
    assign rsp         = out_reg;
    assign ctl.master_mode = master_reg;
    assign ctl.max_slot    = max_slot_reg;
    assign ctl.init_busy   = state_reg == S_INIT;

    assign wrap      = sidx_reg > max_slot_reg;
    assign phase_eff = wrap ? dmx_pkg::PH_BREAK : phase_reg;
    assign sidx_eff  = wrap ? SW'(1) : sidx_reg;

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        pend_next      = pend_reg;
        master_next    = master_reg;
        enable_next    = enable_reg;
        max_slot_next  = max_slot_reg;
        dev_next       = dev_reg;
        phase_next     = phase_reg;
        sidx_next      = sidx_reg;
        ridx_next      = ridx_reg;
        busy_next      = busy_reg;
        latch_next     = latch_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        s_we    = 1'b0;
        s_waddr = cmd.slot;
        s_wdata = cmd.data;
        s_raddr = cmd.slot;
        r_we    = 1'b0;
        r_waddr = ridx_reg;
        r_wdata = cmd.data;
        r_raddr = cmd.slot;

        if (cfg_valid)
        begin
            case (cfg_index)
                dmx_pkg::CFG_MASTER:
                    master_next = cfg_data[0];
                dmx_pkg::CFG_ENABLE:
                begin
                    enable_next = cfg_data[0];
                    if (!cfg_data[0])
                        busy_next = 1'b0;
                end
                dmx_pkg::CFG_MAXSLOT:
                begin
                    if (cfg_data == '0)
                        max_slot_next = SW'(1);
                    else if (cfg_data > LAST)
                        max_slot_next = LAST;
                    else
                        max_slot_next = cfg_data;
                end
                default:
                    dev_next = cfg_data[dmx_pkg::ADDR_W-1:0];
            endcase
        end

        case (state_reg)
            S_INIT:
            begin
                s_we    = 1'b1;
                r_we    = 1'b1;
                s_waddr = sweep_reg;
                r_waddr = sweep_reg;
                s_wdata = '0;
                r_wdata = '0;
                sweep_next = sweep_reg + SW'(1);
                if (sweep_reg == LAST)
                    state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                s_we    = 1'b1;
                s_waddr = sweep_reg;
                s_wdata = '0;
                sweep_next = sweep_reg + SW'(1);
                if (sweep_reg == LAST)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.dimmer_level = latch_reg;
                end
            end
            S_READ:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                out_next       = '0;
                out_next.dimmer_level = latch_reg;
                case (pend_reg)
                    dmx_pkg::K_TX:
                    begin
                        out_next.tx_valid = 1'b1;
                        out_next.tx_byte  = s_rdata_reg;
                    end
                    dmx_pkg::K_READ_TX:
                        out_next.read_value = s_rdata_reg;
                    dmx_pkg::K_READ_RX:
                        out_next.read_value = r_rdata_reg;
                    default:
                    begin
                        latch_next = r_rdata_reg;
                        out_next.dimmer_level = r_rdata_reg;
                    end
                endcase
            end
            default:
            begin
                if (pop)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.status       = cmd.status;
                    out_next.dimmer_level = latch_reg;
                    pend_next      = cmd.kind;
                    case (cmd.kind)
                        dmx_pkg::K_TX:
                        begin
                            if (enable_reg)
                            begin
                                sidx_next = sidx_eff;
                                case (phase_eff)
                                    dmx_pkg::PH_BREAK:
                                    begin
                                        phase_next = dmx_pkg::PH_START;
                                        out_next.tx_valid      = 1'b1;
                                        out_next.tx_break_rate = 1'b1;
                                    end
                                    dmx_pkg::PH_START:
                                    begin
                                        phase_next = dmx_pkg::PH_SLOTS;
                                        out_next.tx_valid = 1'b1;
                                    end
                                    default:
                                    begin
                                        s_raddr        = sidx_eff;
                                        sidx_next      = sidx_eff + SW'(1);
                                        out_valid_next = 1'b0;
                                        state_next     = S_READ;
                                    end
                                endcase
                            end
                        end
                        dmx_pkg::K_DISABLE:
                        begin
                            enable_next = 1'b0;
                            busy_next   = 1'b0;
                        end
                        dmx_pkg::K_RX:
                        begin
                            enable_next = 1'b0;
                            busy_next   = 1'b0;
                            r_we        = 1'b1;
                            if (ridx_reg < LAST)
                                ridx_next = ridx_reg + SW'(1);
                        end
                        dmx_pkg::K_RX_BREAK:
                        begin
                            enable_next    = 1'b0;
                            busy_next      = 1'b0;
                            ridx_next      = '0;
                            r_raddr        = {1'b0, dev_reg};
                            out_valid_next = 1'b0;
                            state_next     = S_READ;
                        end
                        dmx_pkg::K_WRITE:
                            s_we = 1'b1;
                        dmx_pkg::K_READ_TX,
                        dmx_pkg::K_READ_RX:
                        begin
                            out_valid_next = 1'b0;
                            state_next     = S_READ;
                        end
                        dmx_pkg::K_CLEAR:
                        begin
                            sweep_next     = '0;
                            out_valid_next = 1'b0;
                            state_next     = S_CLEAR;
                        end
                        dmx_pkg::K_START:
                        begin
                            if (enable_reg && !busy_reg)
                            begin
                                busy_next  = 1'b1;
                                phase_next = dmx_pkg::PH_START;
                                sidx_next  = SW'(1);
                                out_next.tx_valid      = 1'b1;
                                out_next.tx_break_rate = 1'b1;
                            end
                        end
                        default:
                            pend_next = dmx_pkg::K_NOP;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            pend_reg      <= dmx_pkg::K_NOP;
            master_reg    <= 1'b0;
            enable_reg    <= 1'b0;
            max_slot_reg  <= LAST;
            dev_reg       <= '0;
            phase_reg     <= dmx_pkg::PH_BREAK;
            sidx_reg      <= SW'(1);
            ridx_reg      <= '0;
            busy_reg      <= 1'b0;
            latch_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            pend_reg      <= pend_next;
            master_reg    <= master_next;
            enable_reg    <= enable_next;
            max_slot_reg  <= max_slot_next;
            dev_reg       <= dev_next;
            phase_reg     <= phase_next;
            sidx_reg      <= sidx_next;
            ridx_reg      <= ridx_next;
            busy_reg      <= busy_next;
            latch_reg     <= latch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            send_mem[s_waddr] <= s_wdata;
        s_rdata_reg <= send_mem[s_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (r_we)
            recv_mem[r_waddr] <= r_wdata;
        r_rdata_reg <= recv_mem[r_raddr];
    end

endmodule

@@ hw/rtl/dmx_universe_transceiver.sv @@
// dmx_universe_transceiver: top level; front classifier, command queue, back end.
// Depends on dmx_pkg, dmx_front, dmx_cmd_fifo, dmx_back.
//
// channel  signals                               width
// req      req_valid / req_ready / req           22
// rsp      rsp_valid / rsp_ready / rsp           28
// cfg      cfg_valid / cfg_ready / cfg_index     2 + 10 data
//
// A request passes the command queue and the result register; a slot table read
// also passes the registered memory read port. Clear writes one entry per cycle.
// After reset a clearing pass zeroes both tables; req_ready stays low meanwhile.
// A two-entry queue lets requests enter while a result waits on rsp_ready.
`timescale 1ns / 1ps

module dmx_universe_transceiver (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  dmx_pkg::req_t         req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output dmx_pkg::rsp_t         rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [9:0]            cfg_data
);

    dmx_pkg::front_ctl_t ctl;
    dmx_pkg::cmd_t       push_cmd, pop_cmd;
    logic                push, pop, full, empty;

    assign cfg_ready = 1'b1;

    dmx_front u_front (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .ctl       (ctl),
        .fifo_full (full),
        .push      (push),
        .cmd       (push_cmd)
    );

    dmx_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (full),
        .empty    (empty)
    );

    dmx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fifo_empty (empty),
        .cmd        (pop_cmd),
        .pop        (pop),
        .ctl        (ctl),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

@@ hw/rtl/dmx_checker.sv @@
// dmx_checker: port-level assertions for the transceiver, bound to the top.
// Depends on dmx_pkg and dmx_universe_transceiver.
`timescale 1ns / 1ps

module dmx_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input dmx_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status != 2'd3)
        else $error("bad status code");

    a_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.tx_valid |-> rsp.tx_byte == '0 && !rsp.tx_break_rate)
        else $error("tx payload without tx_valid");

    a_break: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.tx_break_rate |-> rsp.tx_byte == '0 && rsp.read_value == '0)
        else $error("break byte not zero");

endmodule

bind dmx_universe_transceiver dmx_checker u_dmx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
